/* rtl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque: command and status codes,
// cell operations, controller states and walk modes.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Command codes carried in the func field
    typedef enum logic [3:0] {
        FN_PUSH_FRONT = 4'd0,
        FN_PUSH_BACK  = 4'd1,
        FN_POP_FRONT  = 4'd2,
        FN_POP_BACK   = 4'd3,
        FN_CLEAR      = 4'd4,
        FN_REMOVE     = 4'd5,
        FN_READ_FIRST = 4'd6,
        FN_READ_LAST  = 4'd7,
        FN_READ_ALL   = 4'd8
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    // Operation applied to all cells of the chain together
    typedef enum logic [2:0] {
        CELL_HOLD,     // keep contents
        CELL_SHL,      // take the right-hand neighbour (shift towards the front)
        CELL_SHR,      // take the left-hand neighbour, cell 0 takes the key
        CELL_ROT,      // shift towards the front, tail cell takes cell 0
        CELL_APPEND    // selected cell takes the key
    } cell_op_t;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    // Kind of walk round the held entries
    typedef enum logic {
        WALK_REMOVE,
        WALK_READ
    } walk_mode_t;

    localparam int KEY_W   = 32;
    localparam int FUNC_W  = 4;
    localparam int COUNT_W = 7;

endpackage

/* rtl/bdq_cmd_if.sv */
// ----------------------------------------------------------------------------
// bdq_cmd_if
// Command channel of the deque: valid/ready handshake with func, key, count.
// ----------------------------------------------------------------------------
interface bdq_cmd_if
    import bdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [KEY_W-1:0]  key;
    logic [COUNT_W-1:0]       count;

    modport source
    (
        output valid,
        output func,
        output key,
        output count,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  func,
        input  key,
        input  count,
        output ready
    );
endinterface

/* rtl/bdq_rsp_if.sv */
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Result channel of the deque: valid/ready handshake with value, has_value,
// status and last marker.
// ----------------------------------------------------------------------------
interface bdq_rsp_if
    import bdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [KEY_W-1:0]  value;
    logic                     has_value;
    logic [1:0]               status;
    logic                     last;

    modport source
    (
        output valid,
        output value,
        output has_value,
        output status,
        output last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  value,
        input  has_value,
        input  status,
        input  last,
        output ready
    );
endinterface

/* rtl/bounded_deque_with_key_delete_core.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_key_delete_core
// Bounded double-ended queue of signed keys held front-to-back in a chain of
// cells, with key removal and streamed reads done by rotating the chain.
// ----------------------------------------------------------------------------
// Push, pop and clear: the result is registered and appears in the cycle after the command is taken.
// Remove and reads: the chain rotates once per cycle, while the result slot is free,
// through all held entries, and the next command is taken only after the walk;
// with nothing to walk, a status-only result is registered as for a push.
// Reset clears the fill count and the controller; cell contents are not reset.
// ----------------------------------------------------------------------------
module bounded_deque_with_key_delete_core
    import bdq_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    bdq_cmd_if.sink    cmd,
    bdq_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Chain wiring
    logic signed [KEY_W-1:0] cell_q [CAPACITY];
    cell_op_t                cell_op;
    logic [IDX_W-1:0]        cell_sel;

    // Control state
    state_t             state_reg, state_next;
    walk_mode_t         mode_reg, mode_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   first_reg, first_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic               found_reg, found_next;
    logic signed [KEY_W-1:0] key_reg, key_next;

    // Output register
    logic                    rsp_vld_reg, rsp_vld_next;
    logic signed [KEY_W-1:0] value_reg, value_next;
    logic                    has_reg, has_next;
    status_t                 status_reg, status_next;
    logic                    last_reg, last_next;

    // Decode helpers
    logic             slot_free;
    logic             cmd_acc;
    logic             adv;
    logic             last_step;
    logic             is_full;
    logic             is_empty;
    logic             is_match;
    func_t            func;
    logic [7:0]       cnt_ext;
    logic [7:0]       fill_ext;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] tail_cnt;

    assign func      = func_t'(cmd.func);
    assign slot_free = !rsp_vld_reg || rsp.ready;
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign adv       = (state_reg == S_WALK) && slot_free;
    assign last_step = (step_reg == (total_reg - CNT_W'(1)));
    assign is_full   = (fill_reg == CNT_W'(CAPACITY));
    assign is_empty  = (fill_reg == '0);
    assign is_match  = (mode_reg == WALK_REMOVE) && !found_reg && (cell_q[0] == key_reg);
    assign cnt_ext   = 8'(cmd.count);
    assign fill_ext  = 8'(fill_reg);
    assign n_cnt     = (cnt_ext < fill_ext) ? CNT_W'(cnt_ext) : fill_reg;
    assign tail_cnt  = fill_reg - CNT_W'(1);

    // Chain of cells, front at cell 0
    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        logic signed [KEY_W-1:0] left_d;
        logic signed [KEY_W-1:0] right_d;

        if (j == 0)
        begin : g_first
            assign left_d = cmd.key;
        end
        else
        begin : g_mid_l
            assign left_d = cell_q[j-1];
        end

        if (j == CAPACITY - 1)
        begin : g_end
            assign right_d = cell_q[j];
        end
        else
        begin : g_mid_r
            assign right_d = cell_q[j+1];
        end

        bdq_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .idx        (IDX_W'(j)),
            .op         (cell_op),
            .sel        (cell_sel),
            .from_left  (left_d),
            .from_right (right_d),
            .wrap_in    (cell_q[0]),
            .key        (cmd.key),
            .q          (cell_q[j])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    if (func == FN_REMOVE && !is_empty)
                        state_next = S_WALK;
                    else if ((func == FN_READ_FIRST || func == FN_READ_LAST)
                             && n_cnt != '0)
                        state_next = S_WALK;
                    else if (func == FN_READ_ALL && !is_empty)
                        state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (adv && last_step)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs: handshake and cell control
    always_comb
    begin
        cmd.ready = (state_reg == S_IDLE) && slot_free;
        cell_op   = CELL_HOLD;
        cell_sel  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && slot_free)
                begin
                    case (func)
                        FN_PUSH_FRONT:
                        begin
                            if (!is_full)
                                cell_op = CELL_SHR;
                        end
                        FN_PUSH_BACK:
                        begin
                            if (!is_full)
                            begin
                                cell_op  = CELL_APPEND;
                                cell_sel = fill_reg[IDX_W-1:0];
                            end
                        end
                        FN_POP_FRONT:
                        begin
                            if (!is_empty)
                                cell_op = CELL_SHL;
                        end
                        default: cell_op = CELL_HOLD;
                    endcase
                end
            end
            S_WALK:
            begin
                if (adv)
                begin
                    if (is_match)
                        cell_op = CELL_SHL;
                    else
                    begin
                        cell_op  = CELL_ROT;
                        cell_sel = tail_cnt[IDX_W-1:0];
                    end
                end
            end
            default: cell_op = CELL_HOLD;
        endcase
    end

    // Datapath: counters, walk bookkeeping and the result register
    always_comb
    begin
        mode_next    = mode_reg;
        fill_next    = fill_reg;
        step_next    = step_reg;
        total_next   = total_reg;
        first_next   = first_reg;
        end_next     = end_reg;
        found_next   = found_reg;
        key_next     = key_reg;
        rsp_vld_next = rsp.ready ? 1'b0 : rsp_vld_reg;
        value_next   = value_reg;
        has_next     = has_reg;
        status_next  = status_reg;
        last_next    = last_reg;

        if (state_reg == S_IDLE && cmd_acc)
        begin
            // Status-only result by default; reads override below
            value_next  = '0;
            has_next    = 1'b0;
            last_next   = 1'b1;
            status_next = STAT_OK;
            step_next   = '0;
            total_next  = fill_reg;
            found_next  = 1'b0;
            key_next    = cmd.key;
            case (func)
                FN_PUSH_FRONT, FN_PUSH_BACK:
                begin
                    rsp_vld_next = 1'b1;
                    if (is_full)
                        status_next = STAT_FULL;
                    else
                        fill_next = fill_reg + CNT_W'(1);
                end
                FN_POP_FRONT, FN_POP_BACK:
                begin
                    rsp_vld_next = 1'b1;
                    if (is_empty)
                        status_next = STAT_EMPTY;
                    else
                        fill_next = fill_reg - CNT_W'(1);
                end
                FN_CLEAR:
                begin
                    rsp_vld_next = 1'b1;
                    fill_next    = '0;
                end
                FN_REMOVE:
                begin
                    mode_next = WALK_REMOVE;
                    if (is_empty)
                    begin
                        rsp_vld_next = 1'b1;
                        status_next  = STAT_EMPTY;
                    end
                end
                FN_READ_FIRST, FN_READ_LAST, FN_READ_ALL:
                begin
                    mode_next = WALK_READ;
                    if (func == FN_READ_ALL)
                    begin
                        first_next = '0;
                        end_next   = fill_reg;
                    end
                    else if (func == FN_READ_FIRST)
                    begin
                        first_next = '0;
                        end_next   = n_cnt;
                    end
                    else
                    begin
                        first_next = fill_reg - n_cnt;
                        end_next   = fill_reg;
                    end
                    // Nothing to stream: one empty result
                    if (is_empty || (func != FN_READ_ALL && n_cnt == '0))
                    begin
                        rsp_vld_next = 1'b1;
                        status_next  = is_empty ? STAT_EMPTY : STAT_OK;
                    end
                end
                default:
                begin
                    // Unused codes: drop the item
                    rsp_vld_next = rsp.ready ? 1'b0 : rsp_vld_reg;
                    value_next   = value_reg;
                    has_next     = has_reg;
                    last_next    = last_reg;
                    status_next  = status_reg;
                end
            endcase
        end
        else if (adv)
        begin
            // Advance one rotation step
            step_next = step_reg + CNT_W'(1);
            if (mode_reg == WALK_REMOVE)
            begin
                if (is_match)
                begin
                    found_next = 1'b1;
                    fill_next  = fill_reg - CNT_W'(1);
                end
                if (last_step)
                begin
                    rsp_vld_next = 1'b1;
                    value_next   = '0;
                    has_next     = 1'b0;
                    last_next    = 1'b1;
                    status_next  = (found_reg || is_match) ? STAT_OK : STAT_NOTFOUND;
                end
            end
            else
            begin
                if (step_reg >= first_reg && step_reg < end_reg)
                begin
                    rsp_vld_next = 1'b1;
                    value_next   = cell_q[0];
                    has_next     = 1'b1;
                    status_next  = STAT_OK;
                    last_next    = (step_reg == (end_reg - CNT_W'(1)));
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            rsp_vld_reg <= 1'b0;
            mode_reg    <= WALK_READ;
            step_reg    <= '0;
            total_reg   <= '0;
            first_reg   <= '0;
            end_reg     <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rsp_vld_reg <= rsp_vld_next;
            mode_reg    <= mode_next;
            step_reg    <= step_next;
            total_reg   <= total_next;
            first_reg   <= first_next;
            end_reg     <= end_next;
            found_reg   <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        value_reg  <= value_next;
        has_reg    <= has_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // Drive the result channel
    assign rsp.valid     = rsp_vld_reg;
    assign rsp.value     = value_reg;
    assign rsp.has_value = has_reg;
    assign rsp.status    = status_reg;
    assign rsp.last      = last_reg;

endmodule

/* rtl/bdq_cell.sv */
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque chain. Holds one entry and, under the shared
// operation code, takes data from a neighbour, the wrap bus or the key.
// ----------------------------------------------------------------------------
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int IDX_W = 5
)
(
    input  logic                     clk,
    input  logic [IDX_W-1:0]         idx,
    input  cell_op_t                 op,
    input  logic [IDX_W-1:0]         sel,
    input  logic signed [KEY_W-1:0]  from_left,
    input  logic signed [KEY_W-1:0]  from_right,
    input  logic signed [KEY_W-1:0]  wrap_in,
    input  logic signed [KEY_W-1:0]  key,
    output logic signed [KEY_W-1:0]  q
);

    logic signed [KEY_W-1:0] entry_reg;
    logic signed [KEY_W-1:0] entry_next;
    logic                    hit;

    assign hit = (idx == sel);

    // Select the new contents for this cycle
    always_comb
    begin
        case (op)
            CELL_HOLD:   entry_next = entry_reg;
            CELL_SHL:    entry_next = from_right;
            CELL_SHR:    entry_next = from_left;
            CELL_ROT:    entry_next = hit ? wrap_in : from_right;
            CELL_APPEND: entry_next = hit ? key : entry_reg;
            default:     entry_next = entry_reg;
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

/* tb/bounded_deque_with_key_delete_core_tb.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_key_delete_core_tb
// Self-checking bench for the bounded deque. A short table of directed
// commands covers empty and boundary cases, then phased random traffic
// fills, drains and churns the queue. Every accepted command is run through
// a queue-based predictor, and each result item is checked field by field
// against the oldest pending expectation. Both channels idle at random.
// ----------------------------------------------------------------------------
module bounded_deque_with_key_delete_core_tb;
    import bdq_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_ITEMS = 225;
    localparam int STALL_LIMIT  = 2000;
    localparam int N_DIRECTED   = 25;

    // Code outside the command set: the block must ignore it
    localparam logic [FUNC_W-1:0] FN_UNUSED = 4'd9;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic                    has_value;
        status_t                 status;
        logic                    last;
    } deque_result_t;

    typedef struct {
        logic [FUNC_W-1:0]       func;
        logic signed [KEY_W-1:0] key;
        logic [COUNT_W-1:0]      count;
        bit                      typed;
        status_t                 status;
    } cmd_row_t;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    logic clk;
    logic rst_n;

    bdq_cmd_if cmd_ch ();
    bdq_rsp_if rsp_ch ();

    // Predictor state: held keys front to back, and results still owed
    logic signed [KEY_W-1:0] held_keys [$];
    deque_result_t           fresh_results [$];
    deque_result_t           pending_results [$];

    int error_count = 0;
    int idle_cycles = 0;
    int cmd_burst;
    int rsp_burst;

    localparam logic signed [KEY_W-1:0] KEY_POOL [8] = '{
        32'sd0, -32'sd1, KEY_MIN, KEY_MAX, 32'sd1, 32'sd7, 32'sd1000, -32'sd7
    };

    // Directed commands; typed rows carry their single status result
    cmd_row_t directed_rows [N_DIRECTED] = '{
        '{FN_POP_FRONT,  32'sd0,      7'd0,  1'b1, STAT_EMPTY},
        '{FN_POP_BACK,   32'sd0,      7'd0,  1'b1, STAT_EMPTY},
        '{FN_REMOVE,     32'sd5,      7'd0,  1'b1, STAT_EMPTY},
        '{FN_READ_FIRST, 32'sd0,      7'd5,  1'b1, STAT_EMPTY},
        '{FN_READ_LAST,  32'sd0,      7'd0,  1'b1, STAT_EMPTY},
        '{FN_READ_ALL,   32'sd0,      7'd0,  1'b1, STAT_EMPTY},
        '{FN_PUSH_BACK,  KEY_MAX,     7'd0,  1'b1, STAT_OK},
        '{FN_PUSH_FRONT, KEY_MIN,     7'd0,  1'b1, STAT_OK},
        '{FN_PUSH_BACK,  32'sd0,      7'd0,  1'b1, STAT_OK},
        '{FN_PUSH_FRONT, -32'sd1,     7'd0,  1'b1, STAT_OK},
        '{FN_UNUSED,     32'sd99,     7'd3,  1'b0, STAT_OK},
        '{FN_READ_FIRST, 32'sd0,      7'd0,  1'b1, STAT_OK},
        '{FN_READ_ALL,   32'sd0,      7'd0,  1'b0, STAT_OK},
        '{FN_READ_LAST,  32'sd0,      7'd2,  1'b0, STAT_OK},
        '{FN_READ_FIRST, 32'sd0,      7'd64, 1'b0, STAT_OK},
        '{FN_REMOVE,     32'sd12345,  7'd0,  1'b1, STAT_NOTFOUND},
        '{FN_PUSH_BACK,  KEY_MAX,     7'd0,  1'b1, STAT_OK},
        '{FN_REMOVE,     KEY_MAX,     7'd0,  1'b1, STAT_OK},
        '{FN_READ_ALL,   32'sd0,      7'd0,  1'b0, STAT_OK},
        '{FN_POP_FRONT,  32'sd0,      7'd0,  1'b1, STAT_OK},
        '{FN_POP_BACK,   32'sd0,      7'd0,  1'b1, STAT_OK},
        '{FN_CLEAR,      32'sd0,      7'd0,  1'b1, STAT_OK},
        '{FN_PUSH_FRONT, 32'sd42,     7'd0,  1'b1, STAT_OK},
        '{FN_POP_BACK,   32'sd0,      7'd0,  1'b1, STAT_OK},
        '{FN_READ_LAST,  32'sd0,      7'd64, 1'b1, STAT_EMPTY}
    };

    bounded_deque_with_key_delete_core
    #(
        .CAPACITY (CAPACITY)
    )
    u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void emit_status(status_t st);
        deque_result_t r;
        r.value     = '0;
        r.has_value = 1'b0;
        r.status    = st;
        r.last      = 1'b1;
        fresh_results.push_back(r);
    endfunction

    // Stream n held keys starting at offset first from the front
    function automatic void emit_run(int first, int n);
        deque_result_t r;
        if (n == 0)
        begin
            emit_status(held_keys.size() == 0 ? STAT_EMPTY : STAT_OK);
            return;
        end
        for (int i = 0; i < n; i++)
        begin
            r.value     = held_keys[first + i];
            r.has_value = 1'b1;
            r.status    = STAT_OK;
            r.last      = (i == n - 1);
            fresh_results.push_back(r);
        end
    endfunction

    // Apply one command to the held keys and collect the results it causes
    function automatic void apply_command(logic [FUNC_W-1:0] f,
                                          logic signed [KEY_W-1:0] k,
                                          logic [COUNT_W-1:0] c);
        int held;
        int n;
        int found_at;
        fresh_results.delete();
        held = held_keys.size();
        n    = (int'(c) < held) ? int'(c) : held;
        case (f)
            FN_PUSH_FRONT, FN_PUSH_BACK:
            begin
                if (held >= CAPACITY)
                    emit_status(STAT_FULL);
                else
                begin
                    if (f == FN_PUSH_FRONT)
                        held_keys.push_front(k);
                    else
                        held_keys.push_back(k);
                    emit_status(STAT_OK);
                end
            end
            FN_POP_FRONT, FN_POP_BACK:
            begin
                if (held == 0)
                    emit_status(STAT_EMPTY);
                else
                begin
                    if (f == FN_POP_FRONT)
                        void'(held_keys.pop_front());
                    else
                        void'(held_keys.pop_back());
                    emit_status(STAT_OK);
                end
            end
            FN_CLEAR:
            begin
                held_keys.delete();
                emit_status(STAT_OK);
            end
            FN_REMOVE:
            begin
                found_at = -1;
                for (int i = 0; i < held; i++)
                begin
                    if (found_at < 0 && held_keys[i] == k)
                        found_at = i;
                end
                if (held == 0)
                    emit_status(STAT_EMPTY);
                else if (found_at < 0)
                    emit_status(STAT_NOTFOUND);
                else
                begin
                    held_keys.delete(found_at);
                    emit_status(STAT_OK);
                end
            end
            FN_READ_FIRST: emit_run(0, n);
            FN_READ_LAST:  emit_run(held - n, n);
            FN_READ_ALL:   emit_run(0, held);
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle cycles before the next item, with occasional back-to-back stretches
    function automatic int idle_draw(ref int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(traffic_mode_t mode);
        int r;
        int w_push;
        int w_pop;
        int w_rem;
        int w_clr;
        logic [FUNC_W-1:0] f;
        case (mode)
            MODE_FILL:  begin w_push = 65; w_pop = 8;  w_rem = 7;  w_clr = 0; end
            MODE_DRAIN: begin w_push = 10; w_pop = 55; w_rem = 15; w_clr = 0; end
            default:    begin w_push = 30; w_pop = 25; w_rem = 15; w_clr = 4; end
        endcase
        r = $urandom_range(0, 99);
        if (r < w_push)
            f = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
        else if (r < w_push + w_pop)
            f = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
        else if (r < w_push + w_pop + w_rem)
            f = FN_REMOVE;
        else if (r < w_push + w_pop + w_rem + w_clr)
            f = FN_CLEAR;
        else if (r < 97)
        begin
            case ($urandom_range(0, 2))
                0:       f = FN_READ_FIRST;
                1:       f = FN_READ_LAST;
                default: f = FN_READ_ALL;
            endcase
        end
        else
            f = FUNC_W'($urandom_range(9, 15));
        return f;
    endfunction

    // Often a small pool so that duplicates and extremes recur
    function automatic logic signed [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 4)
            return KEY_POOL[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return COUNT_W'($urandom_range(0, 12));
        if (r < 9)
            return COUNT_W'($urandom_range(13, 64));
        return $urandom_range(0, 1) ? 7'd64 : 7'd0;
    endfunction

    // Offer one item, hold it until taken, then record what it should cause
    task automatic send_command(logic [FUNC_W-1:0] f, logic signed [KEY_W-1:0] k,
                                logic [COUNT_W-1:0] c, bit typed, status_t st);
        int gap;
        deque_result_t r;
        gap = idle_draw(cmd_burst);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func  <= f;
        cmd_ch.key   <= k;
        cmd_ch.count <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        apply_command(f, k, c);
        if (typed)
        begin
            r.value     = '0;
            r.has_value = 1'b0;
            r.status    = st;
            r.last      = 1'b1;
            pending_results.push_back(r);
        end
        else
        begin
            foreach (fresh_results[i])
                pending_results.push_back(fresh_results[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and field checks
    // ------------------------------------------------------------------------
    initial
    begin
        deque_result_t want;
        int stall;
        rsp_ch.ready <= 1'b0;
        rsp_burst = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = idle_draw(rsp_burst);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
            if (pending_results.size() == 0)
            begin
                $error("result item with no expectation pending");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, rsp_ch.value);
                    error_count++;
                end
                if (rsp_ch.has_value !== want.has_value)
                begin
                    $error("has_value: expected %0d, got %0d",
                           want.has_value, rsp_ch.has_value);
                    error_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("bounded_deque_with_key_delete_core_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [FUNC_W-1:0]       f;
        logic signed [KEY_W-1:0] k;
        logic [COUNT_W-1:0]      c;
        traffic_mode_t           mode;
        int                      phase_left;
        int                      random_items;

        rst_n        <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func  <= '0;
        cmd_ch.key   <= '0;
        cmd_ch.count <= '0;
        cmd_burst    = 0;

        // Hold reset, then release on a clock edge
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_command(directed_rows[i].func, directed_rows[i].key,
                         directed_rows[i].count, directed_rows[i].typed,
                         directed_rows[i].status);
        end

        // Phased random traffic; open with a long fill so the queue saturates
        mode         = MODE_FILL;
        phase_left   = 70;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                mode       = traffic_mode_t'($urandom_range(0, 2));
                phase_left = $urandom_range(30, 70);
            end
            f = pick_func(mode);
            k = pick_key();
            c = pick_count();
            // Aim most removals at a key that is actually held
            if (f == FN_REMOVE && held_keys.size() > 0 && $urandom_range(0, 9) < 7)
                k = held_keys[$urandom_range(0, held_keys.size() - 1)];
            send_command(f, k, c, 1'b0, STAT_OK);
            phase_left--;
            if (f <= FN_READ_ALL)
                random_items++;
        end
        cmd_ch.valid <= 1'b0;

        // Drain outstanding results, then allow any stray ones to show up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 16) @(posedge clk);

        if (error_count == 0)
            $display("bounded_deque_with_key_delete_core_tb OK");
        else
            $display("bounded_deque_with_key_delete_core_tb NOT OK");
        $finish;
    end

endmodule
